// ----- rtl/mbss_pkg.sv -----
`default_nettype none

package mbss_pkg;

  localparam int PatternBytes = 32;
  localparam int WinIdxW      = $clog2(PatternBytes);
  localparam int LenW         = WinIdxW + 1;

  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 6;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t RegPatWord0 = 3'd0;
  localparam cfg_idx_t RegPatWord1 = 3'd1;
  localparam cfg_idx_t RegPatWord2 = 3'd2;
  localparam cfg_idx_t RegPatWord3 = 3'd3;
  localparam cfg_idx_t RegCmpMask  = 3'd4;
  localparam cfg_idx_t RegPatLen   = 3'd5;

  typedef logic [7:0]      byte_t;
  typedef logic [1:0]      count_t;
  typedef logic [LenW-1:0] len_t;

  localparam count_t CountSat = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/masked_byte_signature_scan.sv -----
`default_nettype none

// Wildcard byte signature scanner. Bytes arrive one per beat on the in_ channel
// and are captured in an input register; the compare against the configured
// pattern (up to 32 bytes, compare_mask clear bits are wildcards) is
// combinational between that register and the window/count state, so the block
// sustains one byte per clock unless a scan_end beat waits on a stalled out_.
// A scan_end beat passes the input register, then the result register, to out_.
// Only scan_end beats produce a result; a stall on out_ holds back only a scan_end
// beat, plain bytes keep flowing. Pattern registers are realigned into a per-slot
// compare table registered after a write, so registers must be written while idle.
module masked_byte_signature_scan
  import mbss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready,
  // input channel
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic [31:0]         in_byte_offset,
  input  wire logic                in_region_start,
  input  wire logic                in_scan_end,
  // result channel
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic                out_unique_found,
  output      logic [1:0]          out_match_count,
  output      logic [31:0]         out_match_offset
);

  // configuration registers
  logic [63:0] pat_word_r [4];
  logic [31:0] cmp_mask_r;
  logic [5:0]  pat_len_r;

  // aligned compare table: slot a of the window (age a) against pattern byte len-1-a
  byte_t                  al_pat_r  [PatternBytes];
  logic [PatternBytes-1:0] al_mask_r;
  logic                   len_ok_r;
  len_t                   len_r;
  logic [31:0]            len_m1_r;

  // input register
  logic        s1_valid_r;
  byte_t       s1_data_r;
  logic [31:0] s1_offset_r;
  logic        s1_region_r;
  logic        s1_end_r;

  // scan state
  byte_t       win_r [PatternBytes];
  len_t        fill_r;
  count_t      count_r;
  logic [31:0] start_r;

  // result register
  logic        out_valid_r;
  logic        out_unique_r;
  count_t      out_count_r;
  logic [31:0] out_offset_r;

  logic                        cfg_wr;
  cfg_idx_t                    cfg_idx;
  logic [PatternBytes*8-1:0]   pat_flat;
  len_t                        len_c;
  byte_t                       al_pat_nxt [PatternBytes];
  logic [PatternBytes-1:0]     al_mask_nxt;
  logic [WinIdxW-1:0]          al_idx [PatternBytes];

  logic                        advance;
  byte_t                       win_nxt [PatternBytes];
  len_t                        fill_nxt;
  logic                        hit;
  count_t                      count_nxt;
  logic [31:0]                 start_nxt;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_t'(paddr[CfgAddrW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      RegPatWord0: prdata = pat_word_r[0];
      RegPatWord1: prdata = pat_word_r[1];
      RegPatWord2: prdata = pat_word_r[2];
      RegPatWord3: prdata = pat_word_r[3];
      RegCmpMask:  prdata = {32'd0, cmp_mask_r};
      RegPatLen:   prdata = {58'd0, pat_len_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r[0] <= '0;
      pat_word_r[1] <= '0;
      pat_word_r[2] <= '0;
      pat_word_r[3] <= '0;
      cmp_mask_r    <= '1;
      pat_len_r     <= 6'd32;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegPatWord0: pat_word_r[0] <= pwdata;
        RegPatWord1: pat_word_r[1] <= pwdata;
        RegPatWord2: pat_word_r[2] <= pwdata;
        RegPatWord3: pat_word_r[3] <= pwdata;
        RegCmpMask:  cmp_mask_r    <= pwdata[31:0];
        RegPatLen:   pat_len_r     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // clamp length to the window depth, then realign pattern and mask by age
  assign pat_flat = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};
  assign len_c    = (pat_len_r > 6'(PatternBytes)) ? len_t'(PatternBytes) : len_t'(pat_len_r);

  always_comb begin
    for (int a = 0; a < PatternBytes; a++) begin
      al_idx[a]      = WinIdxW'(len_c - len_t'(1) - len_t'(a));
      al_pat_nxt[a]  = pat_flat[al_idx[a]*8 +: 8];
      al_mask_nxt[a] = (len_t'(a) < len_c) && cmp_mask_r[al_idx[a]];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < PatternBytes; a++) begin
      al_pat_r[a] <= al_pat_nxt[a];
    end
    al_mask_r <= al_mask_nxt;
    len_ok_r  <= (len_c != '0);
    len_r     <= len_c;
    len_m1_r  <= 32'(len_c) - 32'd1;
  end

  // plain bytes never wait; a scan_end beat waits for a free result register
  assign advance  = s1_valid_r && (!s1_end_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r   <= in_data_byte;
      s1_offset_r <= in_byte_offset;
      s1_region_r <= in_region_start;
      s1_end_r    <= in_scan_end;
    end
  end

  always_comb begin
    win_nxt[0] = s1_data_r;
    for (int a = 1; a < PatternBytes; a++) begin
      win_nxt[a] = s1_region_r ? '0 : win_r[a-1];
    end
    if (s1_region_r) begin
      fill_nxt = len_t'(1);
    end else if (fill_r < len_t'(PatternBytes)) begin
      fill_nxt = fill_r + len_t'(1);
    end else begin
      fill_nxt = fill_r;
    end

    hit = len_ok_r && (fill_nxt >= len_r);
    for (int a = 0; a < PatternBytes; a++) begin
      if (al_mask_r[a] && (win_nxt[a] != al_pat_r[a])) begin
        hit = 1'b0;
      end
    end

    count_nxt = count_r;
    start_nxt = start_r;
    if (hit) begin
      start_nxt = s1_offset_r - len_m1_r;
      if (count_r != CountSat) begin
        count_nxt = count_r + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < PatternBytes; a++) begin
        win_r[a] <= '0;
      end
      fill_r  <= '0;
      count_r <= '0;
      start_r <= '0;
    end else if (advance) begin
      if (s1_end_r) begin
        // drop scan state so the next byte opens a fresh scan
        for (int a = 0; a < PatternBytes; a++) begin
          win_r[a] <= '0;
        end
        fill_r  <= '0;
        count_r <= '0;
        start_r <= '0;
      end else begin
        for (int a = 0; a < PatternBytes; a++) begin
          win_r[a] <= win_nxt[a];
        end
        fill_r  <= fill_nxt;
        count_r <= count_nxt;
        start_r <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_end_r) begin
      out_unique_r <= (count_nxt == count_t'(1));
      out_count_r  <= count_nxt;
      out_offset_r <= (count_nxt == count_t'(1)) ? start_nxt : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_unique_found = out_unique_r;
  assign out_match_count  = out_count_r;
  assign out_match_offset = out_offset_r;

endmodule

`default_nettype wire
